[sv/lg_pkg.sv]
// Shared types, constants and helper functions for the life grid engine.
// No dependencies; every other file but lg_grid_ram.sv imports this package.
`default_nettype none

package lg_pkg;

    localparam int ROW_W      = 64;            // cells per row word
    localparam int ROWS_MAX   = 64;            // grid rows held
    localparam int COLS_MAX   = 64;            // grid columns held
    localparam int ADDR_W     = 6;             // row address bits
    localparam int CNT_W      = 7;             // row counts 0..ROWS_MAX+1
    localparam int GEN_W      = 16;            // generation counter
    localparam int CFG_DATA_W = 16;            // widest register
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GENERATION_COUNT = 2'd2;

    localparam logic [CNT_W-1:0] ROWS_LIMIT = CNT_W'(ROWS_MAX);
    localparam logic [CNT_W-1:0] COLS_LIMIT = CNT_W'(COLS_MAX);

    typedef logic [ROW_W-1:0] row_t;

    // result of one row update
    typedef struct packed {
        row_t row;
        logic changed;
    } row_result_t;

    // clamp the row count register to 1..ROWS_MAX
    function automatic logic [CNT_W-1:0] rows_in_use(input logic [CNT_W-1:0] raw);
        logic [CNT_W-1:0] r;
        r = raw;
        if (r == '0)
            r = CNT_W'(1);
        if (r > ROWS_LIMIT)
            r = ROWS_LIMIT;
        return r;
    endfunction

    // live-column mask from the column count register, clamped to 1..COLS_MAX
    function automatic row_t width_mask(input logic [CNT_W-1:0] raw);
        logic [CNT_W-1:0] c;
        c = raw;
        if (c == '0)
            c = CNT_W'(1);
        if (c > COLS_LIMIT)
            c = COLS_LIMIT;
        return {ROW_W{1'b1}} >> (CNT_W'(ROW_W) - c);
    endfunction

endpackage

`default_nettype wire

[sv/life_grid_generations.sv]
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in      | to block  | in_valid/in_stall  | row_cells[63:0], last_row
//  out     | from block| out_valid/out_stall| out_cells[63:0], out_row_index, out_last
//  cfg     | to block  | cfg_wr_en          | cfg_index, cfg_data
//
//  A row beat loads while in_valid is high and in_stall is low. After the last_row
//  beat, each generation makes one grid memory read and one row-unit update per
//  cycle. The run ends early once a generation leaves the grid unchanged.
//  Each result row steps S_EMIT_RD, S_EMIT_LD, S_EMIT_OUT; out_stall holds S_EMIT_OUT.
//  Reset clears control state only; the grid memory needs no clearing pass.
`default_nettype none

module life_grid_generations
    import lg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [ROW_W-1:0]      row_cells,
    input  wire logic                  last_row,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [ROW_W-1:0]           out_cells,
    output logic [ADDR_W-1:0]          out_row_index,
    output logic                       out_last
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_GEN,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_OUT
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     row_count_reg;
    logic [CNT_W-1:0]     column_count_reg;
    logic [GEN_W-1:0]     generation_count_reg;
    logic [CNT_W-1:0]     load_cnt_reg;
    logic [CNT_W-1:0]     valid_rows_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [GEN_W-1:0]     gen_done_reg;
    logic                 changed_reg;
    logic [ADDR_W-1:0]    emit_idx_reg;
    logic [ADDR_W-1:0]    rd_row_reg;
    row_t                 up_reg;
    row_t                 mid_reg;
    logic                 out_valid_reg;
    row_t                 out_cells_reg;
    logic [ADDR_W-1:0]    out_row_index_reg;
    logic                 out_last_reg;

    logic [CNT_W-1:0]     rows;
    row_t                 mask;
    logic [CNT_W-1:0]     load_ptr;
    logic                 load_fire;
    logic                 load_room;
    row_t                 rd_fmt;
    row_t                 dn_row;
    logic                 pass_end;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    row_t                 mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;
    row_t                 mem_rdata;
    row_result_t          unit_out;

    assign rows      = rows_in_use(row_count_reg);
    assign mask      = width_mask(column_count_reg);
    assign load_ptr  = (load_cnt_reg > rows) ? rows : load_cnt_reg;
    assign load_room = (load_ptr < rows);
    assign in_stall  = (state_reg != S_LOAD);
    assign load_fire = in_valid && !in_stall;

    // rows never written in this load read as dead; old columns masked off
    assign rd_fmt   = ({1'b0, rd_row_reg} < valid_rows_reg) ? (mem_rdata & mask) : '0;
    // below the last row is the dead border
    assign dn_row   = (cnt_reg <= rows) ? rd_fmt : '0;
    assign pass_end = (cnt_reg == rows + CNT_W'(1));

    lg_row_unit u_row (
        .up     (up_reg),
        .mid    (mid_reg),
        .dn     (dn_row),
        .mask   (mask),
        .result (unit_out)
    );

    lg_grid_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS_MAX)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = load_ptr[ADDR_W-1:0];
        mem_wdata = row_cells & mask;
        mem_raddr = emit_idx_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                mem_we = load_fire && load_room;
            end
            S_GEN:
            begin
                // update runs two rows behind the read, so in-place is safe
                mem_raddr = cnt_reg[ADDR_W-1:0];
                mem_we    = (cnt_reg >= CNT_W'(2));
                mem_waddr = ADDR_W'(cnt_reg - CNT_W'(2));
                mem_wdata = unit_out.row;
            end
            S_EMIT_RD, S_EMIT_LD, S_EMIT_OUT:
            begin
                mem_raddr = emit_idx_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg        <= CNT_W'(64);
            column_count_reg     <= CNT_W'(64);
            generation_count_reg <= GEN_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT:        row_count_reg        <= cfg_data[CNT_W-1:0];
                REG_COLUMN_COUNT:     column_count_reg     <= cfg_data[CNT_W-1:0];
                REG_GENERATION_COUNT: generation_count_reg <= cfg_data[GEN_W-1:0];
                default:              row_count_reg        <= row_count_reg;
            endcase
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        rd_row_reg <= mem_raddr;
        if (state_reg == S_GEN)
        begin
            if (cnt_reg == CNT_W'(1))
            begin
                up_reg  <= '0;
                mid_reg <= dn_row;
            end
            else if (cnt_reg >= CNT_W'(2))
            begin
                up_reg  <= mid_reg;
                mid_reg <= dn_row;
            end
        end
        if (state_reg == S_EMIT_LD)
        begin
            out_cells_reg     <= rd_fmt;
            out_row_index_reg <= emit_idx_reg;
            out_last_reg      <= (({1'b0, emit_idx_reg} + CNT_W'(1)) == rows);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            load_cnt_reg   <= '0;
            valid_rows_reg <= '0;
            cnt_reg        <= '0;
            gen_done_reg   <= '0;
            changed_reg    <= 1'b0;
            emit_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (load_fire)
                    begin
                        if (last_row)
                        begin
                            valid_rows_reg <= load_room ? load_ptr + CNT_W'(1) : load_ptr;
                            load_cnt_reg   <= '0;
                            cnt_reg        <= '0;
                            gen_done_reg   <= '0;
                            changed_reg    <= 1'b0;
                            emit_idx_reg   <= '0;
                            state_reg      <= (generation_count_reg == '0) ? S_EMIT_RD : S_GEN;
                        end
                        else
                        begin
                            load_cnt_reg <= load_room ? load_ptr + CNT_W'(1) : load_ptr;
                        end
                    end
                end
                S_GEN:
                begin
                    if (pass_end)
                    begin
                        valid_rows_reg <= rows;
                        cnt_reg        <= '0;
                        changed_reg    <= 1'b0;
                        gen_done_reg   <= gen_done_reg + GEN_W'(1);
                        // stop on a fixed point or when the count is reached
                        if (!(changed_reg || unit_out.changed) ||
                            (gen_done_reg + GEN_W'(1) == generation_count_reg))
                            state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                        if ((cnt_reg >= CNT_W'(2)) && unit_out.changed)
                            changed_reg <= 1'b1;
                    end
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LD;
                end
                S_EMIT_LD:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_EMIT_OUT;
                end
                S_EMIT_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            emit_idx_reg <= emit_idx_reg + ADDR_W'(1);
                            state_reg    <= S_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_cells     = out_cells_reg;
    assign out_row_index = out_row_index_reg;
    assign out_last      = out_last_reg;

endmodule

`default_nettype wire

[sv/lg_grid_ram.sv]
// Single-port-write, single-port-read grid memory with registered read data.
// Generic; no package dependency.
`default_nettype none

module lg_grid_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/lg_row_unit.sv]
// Life rule for one row: counts the eight neighbours of every column from
// the rows above, at and below, applies survive/birth and the column mask.
// Depends on lg_pkg.
`default_nettype none

module lg_row_unit
    import lg_pkg::*;
(
    input  wire row_t        up,
    input  wire row_t        mid,
    input  wire row_t        dn,
    input  wire row_t        mask,
    output row_result_t      result
);

    row_t up_l, up_r, mid_l, mid_r, dn_l, dn_r;
    row_t next_row;

    // bit j of *_l holds column j-1, bit j of *_r holds column j+1
    assign up_l  = up << 1;
    assign up_r  = up >> 1;
    assign mid_l = mid << 1;
    assign mid_r = mid >> 1;
    assign dn_l  = dn << 1;
    assign dn_r  = dn >> 1;

    always_comb
    begin
        logic [3:0] n;
        for (int j = 0; j < ROW_W; j++)
        begin
            n = 4'(up_l[j]) + 4'(up[j]) + 4'(up_r[j])
              + 4'(mid_l[j]) + 4'(mid_r[j])
              + 4'(dn_l[j]) + 4'(dn[j]) + 4'(dn_r[j]);
            next_row[j] = (n == 4'd3) || ((n == 4'd2) && mid[j]);
        end
    end

    assign result.row     = next_row & mask;
    assign result.changed = ((next_row & mask) != mid);

endmodule

`default_nettype wire

[sv/lg_checker.sv]
// Port-level checks for life_grid_generations, bound to the top level.
// Depends on lg_pkg.
`default_nettype none

module lg_checker
    import lg_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic                  last_row,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [ROW_W-1:0]      out_cells,
    input wire logic [ADDR_W-1:0]     out_row_index,
    input wire logic                  out_last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_cells)
            && $stable(out_row_index) && $stable(out_last))
        else $error("stalled output beat changed");

    // no load while results are pending
    a_no_load_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result beat is pending");

    // the last-row beat starts a run, so the input closes
    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_row |=> in_stall)
        else $error("input still open after last row");

    // the final result beat reopens the input
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_last |=> !in_stall && !out_valid)
        else $error("block not back to loading after last result");

    // row 63 is always the final row
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_row_index == 6'd63) |-> out_last)
        else $error("row 63 emitted without last mark");

endmodule

bind life_grid_generations lg_checker u_lg_checker (.*);

`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for life_grid_generations: loads grids, runs life generations
// and checks every emitted row against an in-bench prediction. Depends on lg_pkg.
`timescale 1ns / 100ps

module testbench
    import lg_pkg::*;
();

    typedef struct packed {
        row_t                cells;
        logic [ADDR_W-1:0]   index;
        logic                last;
    } emitted_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_ROW_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    row_t                  row_cells = '0;
    logic                  last_row = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    row_t                  out_cells;
    logic [ADDR_W-1:0]     out_row_index;
    logic                  out_last;

    // bench-side copy of the grid and the register settings
    row_t          life_grid [ROWS_MAX];
    int            load_index = 0;
    logic [6:0]    grid_rows = 7'd64;
    logic [6:0]    grid_cols = 7'd64;
    logic [15:0]   grid_gens = 16'd1;
    emitted_row_t  rows_due [$];
    emitted_row_t  oldest_row;

    int unsigned   fail_count = 0;
    int unsigned   stall_left = 0;
    bit            steady = 1'b0;
    logic          out_hold = 1'b0;

    life_grid_generations dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .row_cells     (row_cells),
        .last_row      (last_row),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_cells     (out_cells),
        .out_row_index (out_row_index),
        .out_last      (out_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int clamp_rows(input logic [6:0] raw);
        if (raw == 7'd0)
            return 1;
        if (raw > ROWS_MAX)
            return ROWS_MAX;
        return int'(raw);
    endfunction

    function automatic row_t cols_mask(input logic [6:0] raw);
        row_t m;
        int   c;
        m = '0;
        c = (raw == 7'd0) ? 1 : ((raw > COLS_MAX) ? COLS_MAX : int'(raw));
        for (int i = 0; i < c; i++)
            m[i] = 1'b1;
        return m;
    endfunction

    // one life generation over the rows in use; returns 1 if any cell changed
    function automatic bit step_generation(input int rows, input row_t mask);
        row_t nxt [ROWS_MAX];
        int   n;
        bit   changed;
        changed = 1'b0;
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < ROW_W; c++)
            begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                        if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < rows &&
                            c + dc >= 0 && c + dc < ROW_W)
                            n += life_grid[r + dr][c + dc];
                nxt[r][c] = mask[c] && (n == 3 || (life_grid[r][c] && n == 2));
            end
        end
        for (int r = 0; r < rows; r++)
        begin
            if (nxt[r] != life_grid[r])
                changed = 1'b1;
            life_grid[r] = nxt[r];
        end
        return changed;
    endfunction

    // absorb one accepted row beat; on the last beat run the grid and queue its rows
    function automatic void apply_row_beat(input row_t cells, input logic last);
        int           rows;
        row_t         mask;
        emitted_row_t e;
        rows = clamp_rows(grid_rows);
        mask = cols_mask(grid_cols);
        if (load_index > rows)
            load_index = rows;
        if (load_index < rows)
        begin
            life_grid[load_index] = cells & mask;
            load_index++;
        end
        if (!last)
            return;
        for (int r = load_index; r < rows; r++)
            life_grid[r] = '0;
        for (int g = 0; g < grid_gens; g++)
            if (!step_generation(rows, mask))
                break;
        for (int r = 0; r < rows; r++)
        begin
            e.cells = life_grid[r];
            e.index = ADDR_W'(r);
            e.last  = (r == rows - 1);
            rows_due.push_back(e);
        end
        load_index = 0;
    endfunction

    function automatic int unsigned gap_length();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 75)
            return $urandom_range(1, 3);
        if (sel < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic int unsigned idle_length();
        if (steady || $urandom_range(0, 99) < 65)
            return 0;
        return gap_length();
    endfunction

    function automatic row_t random_row();
        row_t a, b, c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        unique case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return a & b & c;
            4: return a | b;
            default: return a;
        endcase
    endfunction

    // check each row beat that leaves the block, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (rows_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected row beat: cells %h index %0d last %b",
                             out_cells, out_row_index, out_last);
            end
            else
            begin
                oldest_row = rows_due.pop_front();
                if (out_cells !== oldest_row.cells || out_row_index !== oldest_row.index ||
                    out_last !== oldest_row.last)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("row mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                 oldest_row.cells, oldest_row.index, oldest_row.last,
                                 out_cells, out_row_index, out_last);
                end
            end
        end
        if (stall_left != 0)
            stall_left--;
        else if (!steady && $urandom_range(0, 99) < 30)
            stall_left = gap_length();
        out_stall <= out_hold || (stall_left != 0);
    end

    task automatic send_row(input row_t cells, input logic last);
        int unsigned gap;
        gap = idle_length();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        row_cells <= cells;
        last_row  <= last;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        apply_row_beat(cells, last);
    endtask

    // drop valid, drain every expected row, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (rows_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_config(input logic [6:0] rows, input logic [6:0] cols,
                              input logic [15:0] gens);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_ROW_COUNT;
        cfg_data  <= CFG_DATA_W'(rows);
        @(posedge clk);
        cfg_index <= REG_COLUMN_COUNT;
        cfg_data  <= CFG_DATA_W'(cols);
        @(posedge clk);
        cfg_index <= REG_GENERATION_COUNT;
        cfg_data  <= gens;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        grid_rows = rows;
        grid_cols = cols;
        grid_gens = gens;
    endtask

    // reset settings, short load into a 64-row grid
    task automatic test_reset_defaults();
        send_row('1, 1'b0);
        send_row(64'h0000_0000_0000_0004, 1'b0);
        send_row(64'h8000_0000_0000_0007, 1'b1);
    endtask

    // grid passes through untouched; extra rows past the grid are dropped
    task automatic test_zero_generations();
        set_config(7'd3, 7'd127, 16'd0);
        send_row('1, 1'b0);
        send_row('0, 1'b0);
        send_row(64'hA5A5_5A5A_F00F_0FF0, 1'b0);
        send_row(64'h1234_5678_9ABC_DEF0, 1'b0);
        send_row('1, 1'b1);
    endtask

    // zero row and column counts act as one
    task automatic test_single_cell();
        set_config(7'd0, 7'd0, 16'd3);
        send_row('1, 1'b1);
    endtask

    // longest generation count; the grid settles long before it runs out
    task automatic test_long_runs();
        set_config(7'd1, 7'd64, 16'hFFFF);
        send_row('1, 1'b1);
        set_config(7'd4, 7'd10, 16'hFFFF);
        send_row(64'hFFFF_FFFF_FFFF_FC00, 1'b0);
        send_row(64'h0000_0000_0000_0006, 1'b0);
        send_row(64'h0000_0000_0000_0006, 1'b0);
        send_row('0, 1'b1);
    endtask

    // row count above the limit saturates; top column forced dead
    task automatic test_full_height();
        set_config(7'd100, 7'd63, 16'd2);
        send_row('1, 1'b0);
        send_row(64'hC3C3_3C3C_8001_7FFE, 1'b1);
    endtask

    // hold the output long enough that the block backs up its input
    task automatic test_back_pressure();
        set_config(7'd10, 7'd64, 16'd2);
        steady = 1'b1;
        fork
            begin
                out_hold <= 1'b1;
                repeat (300) @(posedge clk);
                out_hold <= 1'b0;
            end
        join_none
        for (int k = 0; k < 30; k++)
            send_row(random_row(), (k % 10) == 9);
        steady = 1'b0;
    endtask

    task automatic test_random_loads();
        int          loaded;
        int          rows_eff;
        int          beats;
        int unsigned kind;
        logic [6:0]  rows_sel;
        logic [6:0]  cols_sel;
        logic [15:0] gens_sel;
        loaded = 0;
        while (loaded < 230)
        begin
            steady = ($urandom_range(0, 5) == 0);
            if (loaded == 0 || $urandom_range(0, 1) == 1)
            begin
                kind = $urandom_range(0, 19);
                rows_sel = (kind == 0) ? 7'd0 : (kind == 1) ? 7'($urandom_range(65, 127)) :
                           (kind == 2) ? 7'd64 : (kind < 6) ? 7'($urandom_range(13, 40)) :
                           7'($urandom_range(2, 12));
                kind = $urandom_range(0, 19);
                cols_sel = (kind == 0) ? 7'd0 : (kind == 1) ? 7'($urandom_range(65, 127)) :
                           (kind == 2) ? 7'd64 : (kind == 3) ? 7'd1 :
                           7'($urandom_range(2, 63));
                kind = $urandom_range(0, 19);
                gens_sel = (kind == 0) ? 16'd0 : (kind == 1) ? 16'($urandom_range(30, 150)) :
                           16'($urandom_range(1, 10));
                set_config(rows_sel, cols_sel, gens_sel);
            end
            rows_eff = clamp_rows(grid_rows);
            kind = $urandom_range(0, 9);
            if (kind == 8 && rows_eff > 1)
                beats = $urandom_range(1, rows_eff - 1);
            else if (kind == 9)
                beats = rows_eff + $urandom_range(1, 3);
            else
                beats = rows_eff;
            for (int i = 0; i < beats; i++)
                send_row(random_row(), i == beats - 1);
            loaded += beats;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_zero_generations();
        test_single_cell();
        test_long_runs();
        test_full_height();
        test_back_pressure();
        test_random_loads();
        settle();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #500_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
